@@ hdl/bvif_pkg.sv @@
// Shared constants, types and the management header ROM of the beacon framer.
package bvif_pkg;

	localparam int unsigned MAX_PAYLOAD  = 2048;
	localparam int unsigned HEADER_BYTES = 36;
	localparam int unsigned LEN_W        = 12;
	localparam int unsigned POS_W        = 6;

	localparam logic [7:0] ELEMENT_TAG = 8'hde;
	localparam logic [7:0] CHUNK_MAX   = 8'd255;
	localparam logic [7:0] SUBSTITUTE  = 8'h3f;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

	localparam logic [POS_W-1:0] POS_ROM_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_ROM_LAST  = POS_W'(HEADER_BYTES - 1);
	localparam logic [POS_W-1:0] POS_TAG       = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_LEN       = POS_W'(HEADER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_DATA      = POS_W'(HEADER_BYTES + 2);

	typedef struct packed {
		logic       mgmt;
		logic       elem;
		logic [7:0] chunk_len;
		logic [7:0] data;
		logic       last;
	} desc_t;

	function automatic logic [7:0] mgmt_rom(input logic [POS_W-1:0] addr);
		logic [7:0] b;
		case (addr)
			6'd0:  b = 8'h80;
			6'd1:  b = 8'h00;
			6'd2:  b = 8'h00;
			6'd3:  b = 8'h00;
			6'd4:  b = 8'hff;
			6'd5:  b = 8'hff;
			6'd6:  b = 8'hff;
			6'd7:  b = 8'hff;
			6'd8:  b = 8'hff;
			6'd9:  b = 8'hff;
			6'd10: b = 8'hde;
			6'd11: b = 8'had;
			6'd12: b = 8'hbe;
			6'd13: b = 8'hef;
			6'd14: b = 8'hde;
			6'd15: b = 8'had;
			6'd16: b = 8'ha1;
			6'd17: b = 8'h00;
			6'd18: b = 8'h64;
			6'd19: b = 8'he6;
			6'd20: b = 8'h0b;
			6'd21: b = 8'h8b;
			6'd22: b = 8'h40;
			6'd23: b = 8'h43;
			6'd32: b = 8'h64;
			6'd33: b = 8'h00;
			6'd34: b = 8'h11;
			6'd35: b = 8'h04;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ hdl/bvif_ctrl.sv @@
// Input stage: frame counters, length register and the registered beat descriptor.
module bvif_ctrl
	import bvif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] payload_length,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	output logic             desc_valid,
	output desc_t            desc,
	input  logic             desc_pop
);

	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] payload_index_q;
	logic [7:0]       chunk_offset_q;
	logic             desc_valid_s1;
	desc_t            desc_s1;

	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] remaining;
	logic             last;
	logic             accept;
	desc_t            next_desc;

	always_comb begin
		if (length_q == '0) begin
			len_eff = LEN_MIN;
		end else if (length_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = length_q;
		end
		remaining = (payload_index_q < len_eff) ? (len_eff - payload_index_q) : LEN_MIN;
		last      = (remaining <= LEN_MIN);
		next_desc.mgmt      = (payload_index_q == '0);
		next_desc.elem      = (chunk_offset_q == '0);
		next_desc.chunk_len = (remaining < LEN_W'(CHUNK_MAX)) ? remaining[7:0] : CHUNK_MAX;
		next_desc.data      = s_tdata[7] ? SUBSTITUTE : s_tdata;
		next_desc.last      = last;
	end

	assign s_tready   = !desc_valid_s1 || desc_pop;
	assign accept     = s_tvalid && s_tready;
	assign desc_valid = desc_valid_s1;
	assign desc       = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q        <= LEN_MIN;
			payload_index_q <= '0;
			chunk_offset_q  <= '0;
			desc_valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				length_q <= payload_length;
			end
			if (accept) begin
				desc_valid_s1 <= 1'b1;
				if (last) begin
					payload_index_q <= '0;
					chunk_offset_q  <= '0;
				end else begin
					payload_index_q <= payload_index_q + LEN_MIN;
					chunk_offset_q  <= (chunk_offset_q >= CHUNK_MAX - 8'd1) ? 8'd0
						: chunk_offset_q + 8'd1;
				end
			end else if (desc_pop) begin
				desc_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= next_desc;
		end
	end

	a_chunk_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_offset_q < CHUNK_MAX)
		else $error("Chunk offset has reached the chunk size.");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		payload_index_q < LEN_MAX)
		else $error("Payload index has reached the maximum payload.");

endmodule

@@ hdl/bvif_emit.sv @@
// Byte sequencer: walks header, element header and payload byte into the output register.
module bvif_emit
	import bvif_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       desc_valid,
	input  desc_t      desc,
	output logic       desc_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_run_end_q;
	logic             out_frame_end_q;

	logic [POS_W-1:0] start_pos;
	logic [POS_W-1:0] cur;
	logic [7:0]       cur_byte;
	logic             final_byte;
	logic             load;

	always_comb begin
		if (desc.mgmt) begin
			start_pos = POS_ROM_FIRST;
		end else if (desc.elem) begin
			start_pos = POS_TAG;
		end else begin
			start_pos = POS_DATA;
		end
		cur = busy_q ? pos_q : start_pos;
		case (cur) inside
			[POS_ROM_FIRST:POS_ROM_LAST]: cur_byte = mgmt_rom(cur);
			POS_TAG:                      cur_byte = ELEMENT_TAG;
			POS_LEN:                      cur_byte = desc.chunk_len;
			default:                      cur_byte = desc.data;
		endcase
	end

	assign final_byte = (cur == POS_DATA);
	assign load       = desc_valid && (!out_valid_q || m_tready);
	assign desc_pop   = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= !final_byte;
				pos_q       <= cur + POS_W'(1);
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q      <= cur_byte;
			out_run_end_q   <= final_byte;
			out_frame_end_q <= final_byte && desc.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_run_end_q;
	assign m_tlast  = out_frame_end_q;

	a_frame_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frame_end_q |-> out_run_end_q)
		else $error("Frame end seen on a beat that does not end its run.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= POS_DATA) && desc_valid)
		else $error("Sequencer position is out of range or has lost its descriptor.");

endmodule

@@ hdl/beacon_vendor_ie_framer.sv @@
// Top level of the beacon vendor element framer.
// An accepted payload beat passes through the descriptor register, then the output register.
// One output beat per cycle while m_tready is high; a payload byte is led by the element header
// at a chunk start and the management header at a frame start, in the single-byte output register.
// A new input beat is taken in the cycle its predecessor's payload byte enters the output register.
// Reset (arst_n low) clears the counters and valid flags and sets the length register to 1.
module beacon_vendor_ie_framer
	import bvif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] payload_length,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] payload_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] tx_byte
	output logic             m_tuser,   // [0] run_end
	output logic             m_tlast
);

	logic  desc_valid;
	desc_t desc;
	logic  desc_pop;

	bvif_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.payload_length (payload_length),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.desc_valid     (desc_valid),
		.desc           (desc),
		.desc_pop       (desc_pop)
	);

	bvif_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_pop   (desc_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the beacon vendor element framer.
module tb
	import bvif_pkg::*;
();

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       run_end;
		logic       frame_end;
	} frame_beat_t;

	typedef enum bit {ROW_BEAT, ROW_LEN} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [11:0] value;
		bit          typed;
		logic [7:0]  want_byte;
		bit          want_end;
	} stim_row_t;

	localparam int N_ROWS = 23;
	localparam int HOLD_CYCLES = 400;

	localparam logic [7:0] MGMT_HDR [HEADER_BYTES] = '{
		8'h80, 8'h00, 8'h00, 8'h00,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hde, 8'had, 8'hbe, 8'hef, 8'hde, 8'had,
		8'ha1, 8'h00, 8'h64, 8'he6, 8'h0b, 8'h8b,
		8'h40, 8'h43,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h64, 8'h00,
		8'h11, 8'h04
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] payload_length;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tuser;
	logic             m_tlast;

	frame_beat_t frame_q[$];
	logic [11:0] frame_len = 12'd1;
	logic [11:0] byte_idx = 12'd0;
	logic [7:0]  chunk_pos = 8'd0;

	int errors = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	stim_row_t dir_rows [N_ROWS];

	beacon_vendor_ie_framer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.payload_length (payload_length),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [11:0] eff_len(input logic [11:0] len);
		if (len == 12'd0) begin
			return LEN_MIN;
		end
		if (len > LEN_MAX) begin
			return LEN_MAX;
		end
		return len;
	endfunction

	// Queues every frame byte that one payload beat produces and advances the counters.
	task automatic predict_frame(input logic [7:0] raw);
		logic [11:0] len;
		logic [11:0] left;
		bit          last;
		len = eff_len(frame_len);
		left = (byte_idx < len) ? len - byte_idx : 12'd1;
		last = (left <= 12'd1);
		if (byte_idx == 12'd0) begin
			for (int i = 0; i < HEADER_BYTES; i++) begin
				frame_q.push_back('{MGMT_HDR[i], 1'b0, 1'b0});
			end
		end
		if (chunk_pos == 8'd0) begin
			frame_q.push_back('{ELEMENT_TAG, 1'b0, 1'b0});
			frame_q.push_back('{(left < 12'(CHUNK_MAX)) ? left[7:0] : CHUNK_MAX, 1'b0, 1'b0});
		end
		frame_q.push_back('{(raw >= 8'h80) ? SUBSTITUTE : raw, 1'b1, last});
		if (last) begin
			byte_idx = 12'd0;
			chunk_pos = 8'd0;
		end else begin
			byte_idx = byte_idx + 12'd1;
			chunk_pos = chunk_pos + 8'd1;
			if (chunk_pos >= CHUNK_MAX) begin
				chunk_pos = 8'd0;
			end
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input bit typed, input logic [7:0] want_byte,
			input bit want_end);
		frame_beat_t tail;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_frame(b);
		if (typed) begin
			tail = frame_q.pop_back();
			tail.tx_byte = want_byte;
			tail.frame_end = want_end;
			frame_q.push_back(tail);
		end
	endtask

	// The length register is only written once the block has drained.
	task automatic set_len(input logic [11:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		payload_length <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_len = v;
	endtask

	function automatic logic [11:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 6) begin
			return 12'd0;
		end
		if (r < 12) begin
			return 12'($urandom_range(2049, 4095));
		end
		if (r < 22 && byte_idx != 12'd0) begin
			return 12'($urandom_range(0, byte_idx));
		end
		return 12'($urandom_range(1, 12));
	endfunction

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_out
		frame_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				$error("tx_byte: expected nothing, got 0x%02h", m_tdata);
				errors++;
			end else begin
				want = frame_q.pop_front();
				if (m_tdata !== want.tx_byte) begin
					$error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, m_tdata);
					errors++;
				end
				if (m_tuser !== want.run_end) begin
					$error("run_end: expected %0b, got %0b", want.run_end, m_tuser);
					errors++;
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int          sent;
		int          n;
		logic [11:0] left;
		cfg_we = 1'b0;
		payload_length = 12'd1;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		arst_n = 1'b0;

		// Rows with a typed byte close a frame, so their frame_end is always set.
		dir_rows = '{
			'{ROW_BEAT, 12'h000, 1'b1, 8'h00, 1'b1},
			'{ROW_BEAT, 12'h0ff, 1'b1, 8'h3f, 1'b1},
			'{ROW_BEAT, 12'h07f, 1'b1, 8'h7f, 1'b1},
			'{ROW_BEAT, 12'h080, 1'b1, 8'h3f, 1'b1},
			'{ROW_LEN,  12'd0,   1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h001, 1'b1, 8'h01, 1'b1},
			'{ROW_LEN,  12'hfff, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h0aa, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h055, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h03f, 1'b0, 8'h00, 1'b0},
			'{ROW_LEN,  12'd2,   1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h0c3, 1'b1, 8'h3f, 1'b1},
			'{ROW_LEN,  12'd3,   1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h010, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h090, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h020, 1'b1, 8'h20, 1'b1},
			'{ROW_LEN,  12'd2049, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h041, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h0fe, 1'b0, 8'h00, 1'b0},
			'{ROW_LEN,  12'd2048, 1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h07e, 1'b0, 8'h00, 1'b0},
			'{ROW_LEN,  12'd1,   1'b0, 8'h00, 1'b0},
			'{ROW_BEAT, 12'h0e0, 1'b1, 8'h3f, 1'b1}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_LEN) begin
				set_len(dir_rows[r].value);
			end else begin
				send_beat(dir_rows[r].value[7:0], dir_rows[r].typed, dir_rows[r].want_byte,
					dir_rows[r].want_end);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 83;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 83;
				end
				default: begin
					gap_pct = 14;
					stall_pct = 14;
				end
			endcase

			if (ph == 0) begin
				// Run one full chunk against a stalled output, then cut the frame short
				// right on the chunk boundary so that the element length reads one.
				set_len(12'd2048);
				hold_req++;
				repeat (255) send_beat(8'($urandom_range(255)), 1'b0, 8'h00, 1'b0);
				set_len(12'($urandom_range(0, 255)));
				send_beat(8'($urandom_range(255)), 1'b0, 8'h00, 1'b0);
			end

			sent = 0;
			while (sent < 6) begin
				set_len(pick_len());
				left = (byte_idx < eff_len(frame_len)) ? eff_len(frame_len) - byte_idx : 12'd1;
				if ($urandom_range(99) < 80) begin
					n = int'(left);
				end else begin
					n = $urandom_range(1, int'(left));
				end
				if (n > 6) begin
					n = 6;
				end
				repeat (n) send_beat(8'($urandom_range(255)), 1'b0, 8'h00, 1'b0);
				sent += n;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
